// ===== hdl/hne_pkg.sv =====
// hne_pkg: shared types and constants of the hdlc nrzi frame encoder
// used by hne_bit_engine, hne_out_buf and hdlc_nrzi_frame_encoder
`default_nettype none

package hne_pkg;

    localparam logic [1:0]  MODE_START       = 2'd0;
    localparam logic [1:0]  MODE_DATA        = 2'd1;
    localparam logic [1:0]  MODE_END         = 2'd2;

    localparam logic [1:0]  CFG_IDX_OPEN     = 2'd0;
    localparam logic [1:0]  CFG_IDX_CLOSE    = 2'd1;

    localparam logic [5:0]  OPEN_FLAG_RESET  = 6'd50;
    localparam logic [5:0]  CLOSE_FLAG_RESET = 6'd20;
    localparam logic [5:0]  OPEN_FLAG_MAX    = 6'd56;
    localparam logic [5:0]  CLOSE_FLAG_MAX   = 6'd40;

    localparam logic [7:0]  FLAG_BYTE        = 8'h7E;
    localparam logic [15:0] CRC_POLY         = 16'h8408;
    localparam logic [15:0] CRC_PRESET       = 16'hFFFF;
    localparam logic [2:0]  STUFF_RUN        = 3'd5;
    localparam logic [2:0]  ONES_MAX         = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_BYTE,
        ST_FINISH
    } hne_state_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_FCS_LO,
        KIND_FCS_HI,
        KIND_FLAG
    } hne_kind_t;

    typedef struct packed {
        logic       push;
        logic       finish;
        logic [7:0] byte_data;
    } hne_emit_t;

endpackage

`default_nettype wire

// ===== hdl/hne_bit_engine.sv =====
// hne_bit_engine: bit-serial sequencer, crc-16, bit stuffing, nrzi and byte packer
// depends on hne_pkg
`default_nettype none

module hne_bit_engine
    import hne_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cmd_valid,
    output logic            cmd_ready,
    input  wire logic [1:0] cmd_mode,
    input  wire logic [7:0] cmd_data,
    input  wire logic [5:0] open_cfg,
    input  wire logic [5:0] close_cfg,
    input  wire logic       buf_rdy,
    output hne_emit_t       emit
);

    hne_state_t  state_reg, state_next;
    hne_kind_t   kind_reg, kind_next;
    logic [7:0]  sh_reg, sh_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic        stuff_reg, stuff_next;
    logic        last_bit_reg, last_bit_next;
    logic [2:0]  ones_reg, ones_next;
    logic        level_reg, level_next;
    logic [15:0] crc_reg, crc_next;
    logic [5:0]  flag_cnt_reg, flag_cnt_next;
    logic [7:0]  pk_sh_reg, pk_sh_next;
    logic [2:0]  pk_cnt_reg, pk_cnt_next;

    logic        emit_en;
    logic        emit_lvl;
    logic        finish_int;
    logic [5:0]  open_n;
    logic [5:0]  close_n;

    assign open_n  = (open_cfg > OPEN_FLAG_MAX) ? OPEN_FLAG_MAX : open_cfg;
    assign close_n = (close_cfg > CLOSE_FLAG_MAX) ? CLOSE_FLAG_MAX : close_cfg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            kind_reg     <= KIND_DATA;
            bit_cnt_reg  <= 3'd0;
            stuff_reg    <= 1'b0;
            last_bit_reg <= 1'b0;
            ones_reg     <= 3'd0;
            level_reg    <= 1'b1;
            crc_reg      <= CRC_PRESET;
            flag_cnt_reg <= 6'd0;
            pk_sh_reg    <= 8'd0;
            pk_cnt_reg   <= 3'd0;
        end else begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            bit_cnt_reg  <= bit_cnt_next;
            stuff_reg    <= stuff_next;
            last_bit_reg <= last_bit_next;
            ones_reg     <= ones_next;
            level_reg    <= level_next;
            crc_reg      <= crc_next;
            flag_cnt_reg <= flag_cnt_next;
            pk_sh_reg    <= pk_sh_next;
            pk_cnt_reg   <= pk_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg <= sh_next;
    end

    always_comb begin
        logic        b;
        logic        lvl_n;
        logic [2:0]  ones_sat;
        logic [15:0] c;
        logic        byte_end;

        state_next    = state_reg;
        kind_next     = kind_reg;
        sh_next       = sh_reg;
        bit_cnt_next  = bit_cnt_reg;
        stuff_next    = stuff_reg;
        last_bit_next = last_bit_reg;
        ones_next     = ones_reg;
        level_next    = level_reg;
        crc_next      = crc_reg;
        flag_cnt_next = flag_cnt_reg;
        cmd_ready     = 1'b0;
        emit_en       = 1'b0;
        emit_lvl      = level_reg;
        finish_int    = 1'b0;
        byte_end      = 1'b0;
        b             = sh_reg[0];
        lvl_n         = b ? level_reg : ~level_reg;
        ones_sat      = (ones_reg == ONES_MAX) ? ONES_MAX : ones_reg + 3'd1;
        c             = crc_reg ^ {15'd0, b};

        case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    bit_cnt_next = 3'd0;
                    stuff_next   = 1'b0;
                    case (cmd_mode)
                        MODE_START: begin
                            state_next = ST_START;
                        end
                        MODE_DATA: begin
                            sh_next    = cmd_data;
                            kind_next  = KIND_DATA;
                            state_next = ST_BYTE;
                        end
                        MODE_END: begin
                            sh_next    = ~crc_reg[7:0];
                            kind_next  = KIND_FCS_LO;
                            state_next = ST_BYTE;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_START: begin
                if (buf_rdy) begin
                    crc_next   = CRC_PRESET;
                    ones_next  = 3'd0;
                    level_next = 1'b1;
                    emit_en    = 1'b1;
                    emit_lvl   = 1'b1;
                    if (open_n != 6'd0) begin
                        sh_next       = FLAG_BYTE;
                        kind_next     = KIND_FLAG;
                        bit_cnt_next  = 3'd0;
                        flag_cnt_next = open_n - 6'd1;
                        state_next    = ST_BYTE;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_BYTE: begin
                if (buf_rdy) begin
                    emit_en = 1'b1;
                    if (stuff_reg) begin
                        // inserted zero after five ones
                        emit_lvl   = ~level_reg;
                        level_next = ~level_reg;
                        ones_next  = 3'd0;
                        stuff_next = 1'b0;
                        byte_end   = last_bit_reg;
                    end else begin
                        emit_lvl     = lvl_n;
                        level_next   = lvl_n;
                        ones_next    = b ? ones_sat : 3'd0;
                        sh_next      = {1'b0, sh_reg[7:1]};
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                        if (kind_reg == KIND_DATA) begin
                            crc_next = c[0] ? ({1'b0, c[15:1]} ^ CRC_POLY) : {1'b0, c[15:1]};
                        end
                        if (kind_reg != KIND_FLAG && b && ones_sat == STUFF_RUN) begin
                            stuff_next    = 1'b1;
                            last_bit_next = (bit_cnt_reg == 3'd7);
                        end else begin
                            byte_end = (bit_cnt_reg == 3'd7);
                        end
                    end
                    if (byte_end) begin
                        bit_cnt_next = 3'd0;
                        case (kind_reg)
                            KIND_FCS_LO: begin
                                sh_next   = ~crc_reg[15:8];
                                crc_next  = {8'd0, crc_reg[15:8]};
                                kind_next = KIND_FCS_HI;
                            end
                            KIND_FCS_HI: begin
                                if (close_n != 6'd0) begin
                                    sh_next       = FLAG_BYTE;
                                    kind_next     = KIND_FLAG;
                                    flag_cnt_next = close_n - 6'd1;
                                end else begin
                                    state_next = ST_FINISH;
                                end
                            end
                            KIND_FLAG: begin
                                if (flag_cnt_reg != 6'd0) begin
                                    sh_next       = FLAG_BYTE;
                                    flag_cnt_next = flag_cnt_reg - 6'd1;
                                end else begin
                                    state_next = ST_FINISH;
                                end
                            end
                            default: begin
                                state_next = ST_FINISH;
                            end
                        endcase
                    end
                end
            end
            ST_FINISH: begin
                if (buf_rdy) begin
                    finish_int = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // byte packer: first line bit ends up in bit 0
    always_comb begin
        pk_sh_next = pk_sh_reg;
        pk_cnt_next = pk_cnt_reg;
        if (emit_en) begin
            pk_sh_next  = {emit_lvl, pk_sh_reg[7:1]};
            pk_cnt_next = pk_cnt_reg + 3'd1;
        end
        emit.push      = emit_en && (pk_cnt_reg == 3'd7);
        emit.finish    = finish_int;
        emit.byte_data = {emit_lvl, pk_sh_reg[7:1]};
    end

endmodule

`default_nettype wire

// ===== hdl/hne_out_buf.sv =====
// hne_out_buf: one-byte hold stage and output register that marks the last byte of an item
// depends on hne_pkg
`default_nettype none

module hne_out_buf
    import hne_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire hne_emit_t  emit,
    output logic            buf_rdy,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_data_reg, pend_data_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg, m_data_next;
    logic       m_last_reg, m_last_next;
    logic       out_free;
    logic       load_out;

    assign out_free = !m_valid_reg || m_tready;
    assign buf_rdy  = !pend_valid_reg || out_free;
    assign load_out = pend_valid_reg && (emit.push || emit.finish);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_data_reg <= pend_data_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
    end

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_data_next  = pend_data_reg;
            m_last_next  = emit.finish;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (emit.push) begin
            pend_valid_next = 1'b1;
            pend_data_next  = emit.byte_data;
        end else if (emit.finish) begin
            pend_valid_next = 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_push_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit.push || emit.finish) |-> buf_rdy)
        else $error("byte handed over while hold stage blocked");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.finish |=> !pend_valid_reg)
        else $error("held byte survives end of item");

    a_finish_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit.finish && pend_valid_reg) |=> (m_tvalid && m_tlast))
        else $error("final byte of item not marked last");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output byte changed while stalled");

endmodule

`default_nettype wire

// ===== hdl/hdlc_nrzi_frame_encoder.sv =====
// a command is taken while idle, then one line bit per cycle while buf_rdy is high, then finish
// data byte: 8 line bits plus up to 2 stuffed zeros
// start: a leading 1 bit, then the open flags; end: fcs low and high bytes, then the close flags
// a byte is released when the next one fills or the item ends
// reset: synchronous, active low; flag counts return to 50 and 20, crc to all ones, level to 1
// depends on hne_pkg, hne_bit_engine, hne_out_buf
`default_nettype none

module hdlc_nrzi_frame_encoder
    import hne_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic [1:0] s_tuser,   // [1:0] mode
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [5:0] cfg_data
);

    logic [5:0] open_cfg_reg, open_cfg_next;
    logic [5:0] close_cfg_reg, close_cfg_next;
    hne_emit_t  emit;
    logic       buf_rdy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_cfg_reg  <= OPEN_FLAG_RESET;
            close_cfg_reg <= CLOSE_FLAG_RESET;
        end else begin
            open_cfg_reg  <= open_cfg_next;
            close_cfg_reg <= close_cfg_next;
        end
    end

    always_comb begin
        open_cfg_next  = open_cfg_reg;
        close_cfg_next = close_cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_OPEN:  open_cfg_next  = cfg_data;
                CFG_IDX_CLOSE: close_cfg_next = cfg_data;
                default: ;
            endcase
        end
    end

    hne_bit_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd_mode  (s_tuser),
        .cmd_data  (s_tdata),
        .open_cfg  (open_cfg_reg),
        .close_cfg (close_cfg_reg),
        .buf_rdy   (buf_rdy),
        .emit      (emit)
    );

    hne_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .emit     (emit),
        .buf_rdy  (buf_rdy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== dv/tb_hdlc_nrzi_frame_encoder.sv =====
// tb_hdlc_nrzi_frame_encoder: self-checking bench for the hdlc nrzi frame encoder, with
// directed frames, then random frames under random flag counts, sender gaps and receiver stalls
// depends on hne_pkg and hdlc_nrzi_frame_encoder
`default_nettype none

module tb_hdlc_nrzi_frame_encoder;
    import hne_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] payload;
    } frame_cmd_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       last;
    } line_out_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic [1:0] s_tuser = MODE_START;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = CFG_IDX_OPEN;
    logic [5:0] cfg_data = 6'd0;

    frame_cmd_t cmd_queue[$];
    line_out_t  line_bytes_due[$];
    line_out_t  item_bytes[$];

    // encoder mirror
    logic [15:0] fcs_reg = CRC_PRESET;
    logic        nrzi_level = 1'b1;
    logic [2:0]  ones_seen = 3'd0;
    logic [2:0]  fill_pos = 3'd0;
    logic [7:0]  fill_byte = 8'd0;
    logic [5:0]  open_flags = OPEN_FLAG_RESET;
    logic [5:0]  close_flags = CLOSE_FLAG_RESET;

    int mismatches = 0;
    int cmds_taken = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_style = 0;
    int style_left = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;

    hdlc_nrzi_frame_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic send_line_bit();
        fill_byte[fill_pos] = nrzi_level;
        fill_pos = fill_pos + 3'd1;
        if (fill_pos == 3'd0) begin
            item_bytes.push_back('{line_byte: fill_byte, last: 1'b0});
            fill_byte = 8'd0;
        end
    endtask

    task automatic send_octet(input logic [7:0] value, input logic with_fcs, input logic stuffed);
        int  k;
        logic b;
        for (k = 0; k < 8; k++) begin
            b = value[k];
            if (with_fcs) begin
                if (fcs_reg[0] ^ b)
                    fcs_reg = (fcs_reg >> 1) ^ CRC_POLY;
                else
                    fcs_reg = fcs_reg >> 1;
            end
            if (!b) begin
                nrzi_level = ~nrzi_level;
                ones_seen = 3'd0;
            end else begin
                if (ones_seen != ONES_MAX)
                    ones_seen = ones_seen + 3'd1;
                if (stuffed && ones_seen == STUFF_RUN) begin
                    send_line_bit();
                    nrzi_level = ~nrzi_level;
                    ones_seen = 3'd0;
                end
            end
            send_line_bit();
        end
    endtask

    task automatic encode_cmd(input logic [1:0] mode, input logic [7:0] payload);
        logic [5:0] flags;
        line_out_t  one;
        item_bytes.delete();
        case (mode)
            MODE_START: begin
                fcs_reg = CRC_PRESET;
                ones_seen = 3'd0;
                nrzi_level = 1'b1;
                send_line_bit();
                flags = (open_flags > OPEN_FLAG_MAX) ? OPEN_FLAG_MAX : open_flags;
                repeat (flags) send_octet(FLAG_BYTE, 1'b0, 1'b0);
            end
            MODE_DATA: begin
                send_octet(payload, 1'b1, 1'b1);
            end
            MODE_END: begin
                send_octet(~fcs_reg[7:0], 1'b0, 1'b1);
                fcs_reg = fcs_reg >> 8;
                send_octet(~fcs_reg[7:0], 1'b0, 1'b1);
                flags = (close_flags > CLOSE_FLAG_MAX) ? CLOSE_FLAG_MAX : close_flags;
                repeat (flags) send_octet(FLAG_BYTE, 1'b0, 1'b0);
            end
            default: ;
        endcase
        while (item_bytes.size() != 0) begin
            one = item_bytes.pop_front();
            one.last = (item_bytes.size() == 0);
            line_bytes_due.push_back(one);
        end
    endtask

    // input driver: bursts with random gaps
    always @(posedge aclk) begin
        logic offer;
        int   r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                cmd_queue.delete(0);
            offer = s_tvalid && !s_tready;
            if (!offer) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (cmd_queue.size() != 0) begin
                    offer = 1'b1;
                    s_tuser <= cmd_queue[0].mode;
                    s_tdata <= cmd_queue[0].payload;
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        r = $urandom_range(0, 3);
                        case (r)
                            0: gap_left = 0;
                            1: gap_left = $urandom_range(1, 3);
                            2: gap_left = $urandom_range(4, 12);
                            default: gap_left = $urandom_range(13, 30);
                        endcase
                    end
                end
            end
            s_tvalid <= offer;
        end
    end

    // output stall pattern, with one long hold-off to back the block up
    always @(posedge aclk) begin
        logic rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (!long_hold_done && cmds_taken >= 80 && cmd_queue.size() > 4) begin
                long_hold_done = 1'b1;
                hold_left = 400;
            end
            if (style_left == 0) begin
                style_left = $urandom_range(16, 96);
                stall_style = $urandom_range(0, 3);
            end else begin
                style_left--;
            end
            if (hold_left != 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (stall_style)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = style_left[1];
                endcase
            end
            m_tready <= rdy;
        end
    end

    // monitor: config and command transfers update the mirror, line bytes are checked
    always @(posedge aclk) begin
        line_out_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_IDX_OPEN)
                    open_flags = cfg_data;
                else if (cfg_index == CFG_IDX_CLOSE)
                    close_flags = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                encode_cmd(s_tuser, s_tdata);
                cmds_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (line_bytes_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("line byte %h last %b with nothing expected", m_tdata, m_tlast);
                end else begin
                    want = line_bytes_due.pop_front();
                    if (m_tdata !== want.line_byte || m_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("line byte mismatch: expected %h last %b, got %h last %b",
                                     want.line_byte, want.last, m_tdata, m_tlast);
                    end
                end
            end
        end
    end

    task automatic add_cmd(input logic [1:0] mode, input logic [7:0] payload);
        cmd_queue.push_back('{mode: mode, payload: payload});
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // all commands taken and all line bytes seen, then room for a byte still in flight
    task automatic settle_block();
        do @(posedge aclk);
        while (cmd_queue.size() != 0 || s_tvalid || line_bytes_due.size() != 0);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 7))
            0: return 8'hFF;
            1: return 8'h7E;
            2: return 8'h1F;
            3: return 8'hF8;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        int         rand_cmds;
        int         r;
        int         nbytes;
        logic [5:0] open_sel;
        logic [5:0] close_sel;
        rand_cmds = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset flag counts, stuffing corners and an unused mode
        add_cmd(MODE_START, 8'hA5);
        add_cmd(MODE_DATA, 8'h00);
        add_cmd(MODE_DATA, 8'hFF);
        add_cmd(MODE_DATA, 8'h7E);
        add_cmd(MODE_DATA, 8'h3E);
        add_cmd(MODE_DATA, 8'h1F);
        add_cmd(MODE_DATA, 8'hF8);
        add_cmd(MODE_DATA, 8'hAA);
        add_cmd(MODE_DATA, 8'h55);
        add_cmd(MODE_DATA, 8'h80);
        add_cmd(MODE_DATA, 8'h01);
        add_cmd(MODE_UNUSED, 8'hFF);
        add_cmd(MODE_END, 8'h00);
        settle_block();

        // no flags; data and end outside a frame
        write_reg(CFG_IDX_OPEN, 6'd0);
        write_reg(CFG_IDX_CLOSE, 6'd0);
        add_cmd(MODE_START, 8'h00);
        add_cmd(MODE_DATA, 8'hFF);
        add_cmd(MODE_END, 8'h00);
        add_cmd(MODE_DATA, 8'hC3);
        add_cmd(MODE_END, 8'hFF);
        settle_block();

        // counts above range saturate
        write_reg(CFG_IDX_OPEN, 6'd63);
        write_reg(CFG_IDX_CLOSE, 6'd63);
        add_cmd(MODE_START, 8'h00);
        add_cmd(MODE_DATA, 8'hFF);
        add_cmd(MODE_END, 8'h00);
        settle_block();

        write_reg(CFG_IDX_OPEN, OPEN_FLAG_MAX);
        write_reg(CFG_IDX_CLOSE, CLOSE_FLAG_MAX);
        add_cmd(MODE_START, 8'h00);
        add_cmd(MODE_DATA, 8'h5A);
        add_cmd(MODE_END, 8'h00);

        while (rand_cmds < 180) begin
            settle_block();
            r = $urandom_range(0, 9);
            case (r)
                0: open_sel = 6'd0;
                1: open_sel = OPEN_FLAG_MAX;
                2: open_sel = 6'd63;
                3: open_sel = 6'd1;
                default: open_sel = 6'($urandom_range(1, 6));
            endcase
            r = $urandom_range(0, 9);
            case (r)
                0: close_sel = 6'd0;
                1: close_sel = CLOSE_FLAG_MAX;
                2: close_sel = 6'($urandom_range(41, 63));
                3: close_sel = 6'd1;
                default: close_sel = 6'($urandom_range(1, 6));
            endcase
            r = $urandom_range(0, 3);
            if (r != 1)
                write_reg(CFG_IDX_OPEN, open_sel);
            if (r != 2)
                write_reg(CFG_IDX_CLOSE, close_sel);

            repeat ($urandom_range(1, 4)) begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    add_cmd(MODE_UNUSED, 8'($urandom));
                end else if (r == 1) begin
                    add_cmd(MODE_DATA, pick_payload());
                    rand_cmds++;
                end else if (r == 2) begin
                    add_cmd(MODE_END, 8'($urandom));
                    rand_cmds++;
                end
                add_cmd(MODE_START, 8'($urandom));
                rand_cmds++;
                if ($urandom_range(0, 3) == 0)
                    nbytes = $urandom_range(0, 2);
                else
                    nbytes = $urandom_range(1, 12);
                repeat (nbytes) begin
                    add_cmd(MODE_DATA, pick_payload());
                    rand_cmds++;
                end
                if ($urandom_range(0, 9) != 0) begin
                    add_cmd(MODE_END, 8'($urandom));
                    rand_cmds++;
                end
            end
        end

        settle_block();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #8000000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
